/* rtl/lpc_pkg.sv */
// Shared types, codes, constants and the brightness table builder for the LED pulse cue controller.
`timescale 1ns / 1ps

package lpc_pkg;

	// Depth of the recently-seen tag ring.
	localparam int SEEN_DEPTH = 8;
	localparam int SEEN_CNT_W = $clog2(SEEN_DEPTH + 1);

	localparam int TAG_W = 16;

	// Only one cue shape is accepted: five pulses of one second each.
	localparam logic [7:0]  CUE_PULSES   = 8'd5;
	localparam logic [15:0] CUE_INTERVAL = 16'd1000;
	localparam int PULSE_MS    = 1000;
	localparam int CUE_TOTAL_MS = 5 * PULSE_MS;

	// Double blink windows of the degraded pattern, in ms within a second.
	localparam int BLINK_PERIOD = 1000;
	localparam int BLINK_ON_A   = 120;
	localparam int BLINK_OFF_A  = 240;
	localparam int BLINK_ON_B   = 360;

	// Reciprocal of 1000 for 32-bit operands: floor(v / 1000) = (v * RECIP_1000) >> RECIP_SHIFT.
	localparam logic [31:0] RECIP_1000  = 32'h10624DD3;
	localparam int          RECIP_SHIFT = 38;

	localparam logic [7:0] FULL_LEVEL = 8'd255;

	// Brightness table: one sine half-period over 1000 ms.
	localparam int ROM_LEN  = 1000;
	localparam int ROM_HALF = ROM_LEN / 2;
	localparam int ROM_AW   = $clog2(ROM_LEN);
	localparam int REM_W    = $clog2(BLINK_PERIOD);

	localparam logic [63:0] PI_Q60   = 64'h3243F6A8885A308D;
	localparam logic [63:0] PI_STEP  = PI_Q60 / 64'd1000;
	localparam logic [63:0] Q30_HALF = 64'h0000_0000_2000_0000;
	localparam logic [63:0] TAYLOR_D1 = 64'd6;
	localparam logic [63:0] TAYLOR_D2 = 64'd20;
	localparam logic [63:0] TAYLOR_D3 = 64'd42;
	localparam logic [63:0] TAYLOR_D4 = 64'd72;
	localparam logic [63:0] TAYLOR_D5 = 64'd110;
	localparam logic [63:0] TAYLOR_D6 = 64'd156;
	localparam logic [63:0] TAYLOR_D7 = 64'd210;

	typedef enum logic [1:0] {
		OP_TICK   = 2'd0,
		OP_START  = 2'd1,
		OP_CANCEL = 2'd2
	} op_t;

	typedef enum logic [1:0] {
		HEALTH_OK       = 2'd0,
		HEALTH_DEGRADED = 2'd1,
		HEALTH_DOWN     = 2'd2
	} health_t;

	typedef enum logic [1:0] {
		RES_ACCEPTED    = 2'd0,
		RES_DUPLICATE   = 2'd1,
		RES_INVALID     = 2'd2,
		RES_UNAVAILABLE = 2'd3
	} result_t;

	typedef enum logic [2:0] {
		MODE_IDLE        = 3'd0,
		MODE_ACTIVE      = 3'd1,
		MODE_COMPLETED   = 3'd2,
		MODE_CANCELLED   = 3'd3,
		MODE_ABORTED     = 3'd4,
		MODE_UNAVAILABLE = 3'd5
	} mode_t;

	typedef enum logic [1:0] {
		ST_IDLE   = 2'd0,
		ST_WORK   = 2'd1,
		ST_COMMIT = 2'd2
	} fsm_t;

	// Control broadcast to every cell of the tag ring.
	typedef struct packed {
		logic             shift;
		logic [TAG_W-1:0] query;
	} cell_ctl_t;

	typedef logic [7:0] rom_arr_t [ROM_LEN];

	// Q30 multiply with rounding, as the table is defined.
	function automatic logic [63:0] q30_mul(input logic [63:0] a, input logic [63:0] b);
		logic [63:0] p;
		p = a * b + Q30_HALF;
		return p >> 30;
	endfunction

	// round(255 * sin(pi * k / 1000)) through an odd Taylor series to x^15.
	function automatic logic [7:0] rom_value(input int k);
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] term;
		logic [63:0] sum;
		logic [63:0] v;
		int kk;
		kk = (k > ROM_HALF) ? (ROM_LEN - k) : k;
		x = (PI_STEP * 64'(kk) + Q30_HALF) >> 30;
		x2 = q30_mul(x, x);
		term = x;
		sum = x;
		term = q30_mul(term, x2) / TAYLOR_D1;
		sum = sum - term;
		term = q30_mul(term, x2) / TAYLOR_D2;
		sum = sum + term;
		term = q30_mul(term, x2) / TAYLOR_D3;
		sum = sum - term;
		term = q30_mul(term, x2) / TAYLOR_D4;
		sum = sum + term;
		term = q30_mul(term, x2) / TAYLOR_D5;
		sum = sum - term;
		term = q30_mul(term, x2) / TAYLOR_D6;
		sum = sum + term;
		term = q30_mul(term, x2) / TAYLOR_D7;
		sum = sum - term;
		v = (64'd255 * sum + Q30_HALF) >> 30;
		if (v > 64'd255) begin
			v = 64'd255;
		end
		return v[7:0];
	endfunction

	function automatic rom_arr_t build_rom();
		rom_arr_t t;
		for (int k = 0; k < ROM_LEN; k++) begin
			t[k] = rom_value(k);
		end
		return t;
	endfunction

endpackage

/* rtl/lpc_seen_cell.sv */
// One cell of the recently-seen tag ring: holds a tag, passes it on, compares it to the query.
`timescale 1ns / 1ps

module lpc_seen_cell
	import lpc_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  cell_ctl_t        ctl,
	input  logic [TAG_W-1:0] tag_in,
	input  logic             filled,
	output logic [TAG_W-1:0] tag_out,
	output logic             hit
);

	logic [TAG_W-1:0] tag_q;
	logic             hit_q;

	// The stored tag is payload and needs no reset; only filled cells match.
	always_ff @(posedge clk) begin
		if (ctl.shift) begin
			tag_q <= tag_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q <= 1'b0;
		end else begin
			hit_q <= filled && (tag_q == ctl.query);
		end
	end

	assign tag_out = tag_q;
	assign hit     = hit_q;

endmodule

/* rtl/lpc_mod1000.sv */
// Remainder of a 32-bit millisecond time by 1000 through reciprocal multiplication.
`timescale 1ns / 1ps

module lpc_mod1000
	import lpc_pkg::*;
(
	input  logic             clk,
	input  logic [31:0]      value,
	output logic [REM_W-1:0] rem
);

	logic [63:0]              prod_s1;
	logic [31:0]              value_s1;
	logic [63-RECIP_SHIFT:0]  quot_v;
	logic [31:0]              back_v;
	logic [31:0]              diff_v;
	logic [REM_W-1:0]         rem_s2;

	// The quotient comes from the product's upper bits; the remainder is what is left
	// after subtracting the quotient times 1000. The input is held for the whole
	// transaction, so the result settles once prod_s1 and rem_s2 have loaded and then stays.
	assign quot_v = prod_s1[63:RECIP_SHIFT];
	assign back_v = 32'(quot_v) * 32'(BLINK_PERIOD);
	assign diff_v = value_s1 - back_v;

	always_ff @(posedge clk) begin
		prod_s1  <= 64'(value) * 64'(RECIP_1000);
		value_s1 <= value;
		rem_s2   <= diff_v[REM_W-1:0];
	end

	assign rem = rem_s2;

endmodule

/* rtl/lpc_bright_rom.sv */
// Sine-envelope brightness table with a registered read port.
`timescale 1ns / 1ps

module lpc_bright_rom
	import lpc_pkg::*;
(
	input  logic              clk,
	input  logic [ROM_AW-1:0] addr,
	output logic [7:0]        data
);

	localparam rom_arr_t ROM_TABLE = build_rom();

	logic [7:0] data_q;

	always_ff @(posedge clk) begin
		data_q <= ROM_TABLE[addr];
	end

	assign data = data_q;

endmodule

/* rtl/led_pulse_cue_controller_unit.sv */
// Top level of the LED pulse cue controller: command checks, cue sequencer and LED drive.
// A result shows on out_valid once the accepted transaction has passed through ST_WORK and ST_COMMIT.
// A new transaction is taken only after the last has committed, and commit waits on a stalled output.
// The pace is set by the work phase that covers the elapsed-time split and ROM read.
// Reset (arst_n low, asynchronous) empties the tag ring count and sets the cue to idle.
// No clearing pass is needed; ring contents past the fill count are never compared.
`timescale 1ns / 1ps

module led_pulse_cue_controller_unit
	import lpc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,

	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  op,
	input  logic [15:0] cue_tag,
	input  logic [7:0]  pulse_count,
	input  logic [15:0] interval_ms,
	input  logic [31:0] now_ms,
	input  logic [1:0]  health,
	input  logic [7:0]  normal_red,
	input  logic [7:0]  normal_green,
	input  logic [7:0]  normal_blue,
	input  logic [7:0]  normal_brightness,
	input  logic        normal_on,

	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  command_result,
	output logic [7:0]  out_red,
	output logic [7:0]  out_green,
	output logic [7:0]  out_blue,
	output logic [7:0]  out_brightness,
	output logic        out_on,
	output logic [2:0]  cue_phase_state,
	output logic [7:0]  pulses_done
);

	// ------------------------------------------------------------------
	// Sequencer. An input transaction is taken only in ST_IDLE. ST_WORK
	// follows, in which the tag ring compares, the elapsed time is
	// split into pulse number and ROM index, the ROM is read and the blink
	// phase remainder finishes. ST_COMMIT then updates the cue state and
	// loads the output register once that register is free.
	// ------------------------------------------------------------------
	fsm_t       state_q, state_d;
	logic [1:0] work_cnt_q;
	logic       accept;
	logic       out_free;
	logic       commit_fire;

	// Captured input transaction.
	logic [1:0]       op_q;
	logic [TAG_W-1:0] tag_q;
	logic [7:0]       pcount_q;
	logic [15:0]      ival_q;
	logic [31:0]      now_q;
	logic [1:0]       health_q;
	logic [7:0]       nred_q, ngreen_q, nblue_q, nbright_q;
	logic             non_q;

	// Cue state.
	logic [SEEN_CNT_W-1:0] count_q;
	logic [TAG_W-1:0]      active_tag_q;
	logic [31:0]           start_q;
	logic [7:0]            pulses_q;
	mode_t                 mode_q;

	// Elapsed-time pipeline.
	logic [31:0]       elapsed_s1;
	logic              done_s2;
	logic [2:0]        pulses_s2;
	logic [ROM_AW-1:0] idx_s2;
	logic              done_v;
	logic [2:0]        pulses_v;
	logic [12:0]       base_v;

	// Tag ring.
	cell_ctl_t        cell_ctl;
	logic [TAG_W-1:0] tag_link [SEEN_DEPTH];
	logic [SEEN_DEPTH-1:0] cell_hit;
	logic             seen_hit;

	logic [7:0]       rom_data;
	logic [REM_W-1:0] phase_ms;

	// Commit decisions.
	result_t     res_d;
	logic [7:0]  red_d, green_d, blue_d, bright_d;
	logic        on_d;
	mode_t       mode_d;
	logic [7:0]  pulses_d;
	logic        store_en;
	logic        restart_en;
	logic        blink_lit;

	// Output register.
	logic        out_valid_q;
	logic [1:0]  res_q;
	logic [7:0]  red_q, green_q, blue_q, bright_q;
	logic        on_q;
	logic [2:0]  phase_state_q;
	logic [7:0]  pulses_out_q;

	assign out_free = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			work_cnt_q <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_WORK) begin
				work_cnt_q <= work_cnt_q + 2'd1;
			end else begin
				work_cnt_q <= '0;
			end
		end
	end

	always_comb begin
		state_d     = state_q;
		in_stall    = 1'b1;
		accept      = 1'b0;
		commit_fire = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				accept   = in_valid;
				if (in_valid) begin
					state_d = ST_WORK;
				end
			end
			ST_WORK: begin
				if (work_cnt_q == 2'd3) begin
					state_d = ST_COMMIT;
				end
			end
			ST_COMMIT: begin
				if (out_free) begin
					commit_fire = 1'b1;
					state_d     = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// The transaction is held here for the whole item.
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q      <= op;
			tag_q     <= cue_tag;
			pcount_q  <= pulse_count;
			ival_q    <= interval_ms;
			now_q     <= now_ms;
			health_q  <= health;
			nred_q    <= normal_red;
			ngreen_q  <= normal_green;
			nblue_q   <= normal_blue;
			nbright_q <= normal_brightness;
			non_q     <= normal_on;
		end
	end

	// ------------------------------------------------------------------
	// Tag ring as a chain of cells. A new tag enters cell 0 and every cell
	// hands its tag to the next one, so the oldest tag falls off the end.
	// Cells below the fill count take part in the search.
	// ------------------------------------------------------------------
	assign cell_ctl.shift = commit_fire && store_en;
	assign cell_ctl.query = tag_q;

	for (genvar i = 0; i < SEEN_DEPTH; i++) begin : g_cell
		logic [TAG_W-1:0] tag_in_w;
		logic             filled_w;

		if (i == 0) begin : g_head
			assign tag_in_w = tag_q;
		end else begin : g_body
			assign tag_in_w = tag_link[i - 1];
		end
		assign filled_w = count_q > SEEN_CNT_W'(i);

		lpc_seen_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.ctl     (cell_ctl),
			.tag_in  (tag_in_w),
			.filled  (filled_w),
			.tag_out (tag_link[i]),
			.hit     (cell_hit[i])
		);
	end

	// An empty tag is never reported as seen.
	assign seen_hit = (|cell_hit) && (tag_q != '0);

	// ------------------------------------------------------------------
	// Elapsed time of a running cue. A running cue always has five pulses
	// of 1000 ms, so the pulse number and the offset within the pulse come
	// from four parallel threshold compares.
	// ------------------------------------------------------------------
	always_comb begin
		done_v   = elapsed_s1 >= 32'(CUE_TOTAL_MS);
		pulses_v = '0;
		base_v   = '0;
		for (int k = 1; k < 5; k++) begin
			if (elapsed_s1 >= 32'(k * PULSE_MS)) begin
				pulses_v = 3'(k);
				base_v   = 13'(k * PULSE_MS);
			end
		end
	end

	always_ff @(posedge clk) begin
		elapsed_s1 <= now_q - start_q;
		done_s2    <= done_v;
		pulses_s2  <= pulses_v;
		if (done_v) begin
			idx_s2 <= '0;
		end else begin
			idx_s2 <= ROM_AW'(elapsed_s1[12:0] - base_v);
		end
	end

	lpc_bright_rom u_rom (
		.clk  (clk),
		.addr (idx_s2),
		.data (rom_data)
	);

	// The blink phase is taken from the held time stamp and stays valid until commit.
	lpc_mod1000 u_phase (
		.clk   (clk),
		.value (now_q),
		.rem   (phase_ms)
	);

	assign blink_lit = (phase_ms < REM_W'(BLINK_ON_A))
		|| ((phase_ms >= REM_W'(BLINK_OFF_A)) && (phase_ms < REM_W'(BLINK_ON_B)));

	// ------------------------------------------------------------------
	// Command and tick decisions, applied in ST_COMMIT.
	// ------------------------------------------------------------------
	always_comb begin
		res_d      = RES_ACCEPTED;
		red_d      = '0;
		green_d    = '0;
		blue_d     = '0;
		bright_d   = '0;
		on_d       = 1'b0;
		mode_d     = mode_q;
		pulses_d   = pulses_q;
		store_en   = 1'b0;
		restart_en = 1'b0;
		unique case (op_q)
			OP_START: begin
				if (tag_q == '0 || pcount_q != CUE_PULSES || ival_q != CUE_INTERVAL) begin
					res_d = RES_INVALID;
				end else if (seen_hit) begin
					res_d = RES_DUPLICATE;
				end else begin
					store_en = 1'b1;
					pulses_d = '0;
					if (health_q != HEALTH_OK) begin
						mode_d = MODE_UNAVAILABLE;
						res_d  = RES_UNAVAILABLE;
					end else begin
						mode_d     = MODE_ACTIVE;
						restart_en = 1'b1;
					end
				end
			end
			OP_CANCEL: begin
				if (mode_q != MODE_ACTIVE || tag_q == '0 || active_tag_q != tag_q) begin
					res_d = seen_hit ? RES_DUPLICATE : RES_INVALID;
				end else begin
					mode_d = MODE_CANCELLED;
				end
			end
			OP_TICK: begin
				red_d    = nred_q;
				green_d  = ngreen_q;
				blue_d   = nblue_q;
				bright_d = nbright_q;
				on_d     = non_q;
				if (health_q == HEALTH_OK) begin
					if (mode_q == MODE_ACTIVE) begin
						if (done_s2) begin
							// The cue has run out: show the normal color.
							pulses_d = CUE_PULSES;
							mode_d   = MODE_COMPLETED;
						end else begin
							pulses_d = {5'd0, pulses_s2};
							red_d    = FULL_LEVEL;
							green_d  = FULL_LEVEL;
							blue_d   = FULL_LEVEL;
							bright_d = rom_data;
							on_d     = 1'b1;
						end
					end
				end else if (health_q == HEALTH_DEGRADED) begin
					if (mode_q == MODE_ACTIVE) begin
						mode_d = MODE_ABORTED;
					end
					if (!blink_lit) begin
						bright_d = '0;
					end
				end else begin
					// Unavailable, and the unused health code, give black.
					if (mode_q == MODE_ACTIVE) begin
						mode_d = MODE_ABORTED;
					end
					red_d    = '0;
					green_d  = '0;
					blue_d   = '0;
					bright_d = '0;
					on_d     = 1'b0;
				end
			end
			default: begin
				// The unused op code changes nothing.
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q      <= '0;
			active_tag_q <= '0;
			start_q      <= '0;
			pulses_q     <= '0;
			mode_q       <= MODE_IDLE;
		end else if (commit_fire) begin
			mode_q   <= mode_d;
			pulses_q <= pulses_d;
			if (store_en) begin
				active_tag_q <= tag_q;
				if (count_q != SEEN_CNT_W'(SEEN_DEPTH)) begin
					count_q <= count_q + SEEN_CNT_W'(1);
				end
			end
			if (restart_en) begin
				start_q <= now_q;
			end
		end
	end

	// Output register: a finished transaction waits here until taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (commit_fire) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (commit_fire) begin
			res_q         <= res_d;
			red_q         <= red_d;
			green_q       <= green_d;
			blue_q        <= blue_d;
			bright_q      <= bright_d;
			on_q          <= on_d;
			phase_state_q <= mode_d;
			pulses_out_q  <= pulses_d;
		end
	end

	assign out_valid       = out_valid_q;
	assign command_result  = res_q;
	assign out_red         = red_q;
	assign out_green       = green_q;
	assign out_blue        = blue_q;
	assign out_brightness  = bright_q;
	assign out_on          = on_q;
	assign cue_phase_state = phase_state_q;
	assign pulses_done     = pulses_out_q;

endmodule

/* rtl/lpc_checker.sv */
// Port-level assertions for the LED pulse cue controller and their binding to the top level.
`timescale 1ns / 1ps

module lpc_assert_checker
	import lpc_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic [1:0]  command_result,
	input logic [7:0]  out_red,
	input logic [7:0]  out_green,
	input logic [7:0]  out_blue,
	input logic [7:0]  out_brightness,
	input logic        out_on,
	input logic [2:0]  cue_phase_state,
	input logic [7:0]  pulses_done
);

	// One transaction at a time: the port closes right after an accept.
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("input accepted while a transaction is in progress");

	// A stalled result holds.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(command_result)
			&& $stable(out_brightness) && $stable(cue_phase_state)))
		else $error("result changed while stalled");

	// Rejected commands carry no LED drive.
	a_cmd_dark: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && command_result != RES_ACCEPTED) |->
			(out_red == 8'd0 && out_green == 8'd0 && out_blue == 8'd0
			&& out_brightness == 8'd0 && !out_on))
		else $error("command result with nonzero color");

	// A running cue has never finished all of its pulses.
	a_active_pulses: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && cue_phase_state == MODE_ACTIVE) |-> (pulses_done < CUE_PULSES))
		else $error("active cue reports all pulses done");

endmodule

bind led_pulse_cue_controller_unit lpc_assert_checker u_lpc_checker (.*);

/* test/lpc_checker.sv */
// Scoreboard for the LED pulse cue controller: watches both channels, predicts and compares.
`timescale 1ns / 1ps

module lpc_checker
	import lpc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,

	input  logic        in_valid,
	input  logic        in_stall,
	input  logic [1:0]  op,
	input  logic [15:0] cue_tag,
	input  logic [7:0]  pulse_count,
	input  logic [15:0] interval_ms,
	input  logic [31:0] now_ms,
	input  logic [1:0]  health,
	input  logic [7:0]  normal_red,
	input  logic [7:0]  normal_green,
	input  logic [7:0]  normal_blue,
	input  logic [7:0]  normal_brightness,
	input  logic        normal_on,

	input  logic        out_valid,
	input  logic        out_stall,
	input  logic [1:0]  command_result,
	input  logic [7:0]  out_red,
	input  logic [7:0]  out_green,
	input  logic [7:0]  out_blue,
	input  logic [7:0]  out_brightness,
	input  logic        out_on,
	input  logic [2:0]  cue_phase_state,
	input  logic [7:0]  pulses_done,

	output int          fail_count,
	output int          pending_results
);

	typedef struct packed {
		result_t    verdict;
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic [7:0] level;
		logic       lit;
		mode_t      phase;
		logic [7:0] pulses;
	} led_frame_t;

	localparam logic [63:0] HALF_TURN_Q60 = 64'h3243F6A8885A308D;
	localparam logic [63:0] Q30_ROUND     = 64'd1 << 29;
	localparam int          SINE_STEPS    = 1000;
	localparam int unsigned BLINK_A_END   = 120;
	localparam int unsigned BLINK_B_START = 240;
	localparam int unsigned BLINK_B_END   = 360;
	localparam int unsigned BLINK_SPAN    = 1000;
	localparam logic [7:0]  GOOD_PULSES   = 8'd5;
	localparam logic [15:0] GOOD_PERIOD   = 16'd1000;

	logic [7:0]  sine_lut [SINE_STEPS];
	logic [15:0] ring_tags [SEEN_DEPTH];
	int unsigned ring_next;
	int unsigned ring_fill;
	mode_t       phase;
	logic [15:0] live_tag;
	logic [31:0] cue_t0;
	logic [7:0]  pulses_so_far;
	logic [7:0]  cue_pulses;
	logic [15:0] cue_period;
	led_frame_t  frames_due [$];
	led_frame_t  want;
	int          mismatches = 0;

	// Half a sine period in Q30, odd Taylor terms up to x^15, scaled to 255.
	function automatic logic [7:0] sine_level(input int k);
		logic [63:0] x, x2, term, acc, scaled;
		int j;
		j = (k > SINE_STEPS / 2) ? SINE_STEPS - k : k;
		x = ((HALF_TURN_Q60 / 64'(SINE_STEPS)) * 64'(j) + Q30_ROUND) >> 30;
		x2 = (x * x + Q30_ROUND) >> 30;
		term = x;
		acc = x;
		for (int n = 1; n <= 7; n++) begin
			term = ((term * x2 + Q30_ROUND) >> 30) / 64'((2 * n) * (2 * n + 1));
			acc = (n % 2 == 1) ? acc - term : acc + term;
		end
		scaled = (64'd255 * acc + Q30_ROUND) >> 30;
		return (scaled > 64'd255) ? 8'd255 : scaled[7:0];
	endfunction

	initial begin
		for (int k = 0; k < SINE_STEPS; k++) begin
			sine_lut[k] = sine_level(k);
		end
	end

	function automatic bit tag_known(input logic [15:0] t);
		if (t == 16'd0) begin
			return 1'b0;
		end
		for (int i = 0; i < ring_fill && i < SEEN_DEPTH; i++) begin
			if (ring_tags[i] == t) begin
				return 1'b1;
			end
		end
		return 1'b0;
	endfunction

	// Moves the cue state by one transaction and works out the LED frame it causes.
	task automatic apply_item(input logic [1:0] cmd, input logic [15:0] tag,
		input logic [7:0] pcount, input logic [15:0] period, input logic [31:0] stamp,
		input logic [1:0] hl, input logic [7:0] r, input logic [7:0] g, input logic [7:0] b,
		input logic [7:0] lvl, input logic lit, output led_frame_t f);
		logic [31:0] elapsed;
		logic [31:0] span;
		logic [31:0] offset;
		int unsigned ms_in_sec;
		f = '0;
		f.verdict = RES_ACCEPTED;
		case (cmd)
			OP_START: begin
				if (tag == 16'd0 || pcount != GOOD_PULSES || period != GOOD_PERIOD) begin
					f.verdict = RES_INVALID;
				end else if (tag_known(tag)) begin
					f.verdict = RES_DUPLICATE;
				end else begin
					ring_tags[ring_next] = tag;
					ring_next = (ring_next + 1) % SEEN_DEPTH;
					if (ring_fill < SEEN_DEPTH) begin
						ring_fill++;
					end
					live_tag = tag;
					pulses_so_far = 8'd0;
					if (hl != HEALTH_OK) begin
						phase = MODE_UNAVAILABLE;
						f.verdict = RES_UNAVAILABLE;
					end else begin
						phase = MODE_ACTIVE;
						cue_t0 = stamp;
						cue_pulses = pcount;
						cue_period = period;
					end
				end
			end
			OP_CANCEL: begin
				if (phase != MODE_ACTIVE || tag == 16'd0 || live_tag != tag) begin
					if (tag_known(tag)) begin
						f.verdict = RES_DUPLICATE;
					end else begin
						f.verdict = RES_INVALID;
					end
				end else begin
					phase = MODE_CANCELLED;
				end
			end
			OP_TICK: begin
				f.red = r;
				f.green = g;
				f.blue = b;
				f.level = lvl;
				f.lit = lit;
				if (hl >= HEALTH_DOWN) begin
					if (phase == MODE_ACTIVE) begin
						phase = MODE_ABORTED;
					end
					f.red = 8'd0;
					f.green = 8'd0;
					f.blue = 8'd0;
					f.level = 8'd0;
					f.lit = 1'b0;
				end else if (hl == HEALTH_DEGRADED) begin
					ms_in_sec = stamp % BLINK_SPAN;
					if (phase == MODE_ACTIVE) begin
						phase = MODE_ABORTED;
					end
					if (!(ms_in_sec < BLINK_A_END ||
						(ms_in_sec >= BLINK_B_START && ms_in_sec < BLINK_B_END))) begin
						f.level = 8'd0;
					end
				end else if (phase == MODE_ACTIVE) begin
					elapsed = stamp - cue_t0;
					span = 32'(cue_pulses) * 32'(cue_period);
					if (elapsed >= span || cue_period == 16'd0) begin
						// The cue has run out: the normal color comes back on this tick.
						pulses_so_far = cue_pulses;
						phase = MODE_COMPLETED;
					end else begin
						offset = elapsed % cue_period;
						pulses_so_far = 8'(elapsed / cue_period);
						f.red = 8'hFF;
						f.green = 8'hFF;
						f.blue = 8'hFF;
						f.level = (offset < SINE_STEPS) ? sine_lut[offset] : 8'd0;
						f.lit = 1'b1;
					end
				end
			end
			default: begin
			end
		endcase
		f.phase = phase;
		f.pulses = pulses_so_far;
	endtask

	task automatic check_field(input string what, input logic [31:0] exp_v,
		input logic [31:0] got_v);
		if (exp_v !== got_v) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, exp_v, got_v);
			mismatches++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ring_next = 0;
			ring_fill = 0;
			phase = MODE_IDLE;
			live_tag = 16'd0;
			cue_t0 = 32'd0;
			pulses_so_far = 8'd0;
			cue_pulses = 8'd0;
			cue_period = 16'd0;
			frames_due.delete();
		end else begin
			if (out_valid && !out_stall) begin
				if (frames_due.size() == 0) begin
					$display("%0t: result with nothing expected, actual result %0d mode %0d",
						$time, command_result, cue_phase_state);
					mismatches++;
				end else begin
					want = frames_due.pop_front();
					check_field("command_result", 32'(want.verdict), 32'(command_result));
					check_field("out_red", 32'(want.red), 32'(out_red));
					check_field("out_green", 32'(want.green), 32'(out_green));
					check_field("out_blue", 32'(want.blue), 32'(out_blue));
					check_field("out_brightness", 32'(want.level), 32'(out_brightness));
					check_field("out_on", 32'(want.lit), 32'(out_on));
					check_field("cue_phase_state", 32'(want.phase), 32'(cue_phase_state));
					check_field("pulses_done", 32'(want.pulses), 32'(pulses_done));
				end
			end
			if (in_valid && !in_stall) begin
				apply_item(op, cue_tag, pulse_count, interval_ms, now_ms, health, normal_red,
					normal_green, normal_blue, normal_brightness, normal_on, want);
				frames_due.push_back(want);
			end
		end
		fail_count <= mismatches;
		pending_results <= frames_due.size();
	end

endmodule

/* test/tb_top.sv */
// Testbench top for the LED pulse cue controller: clock, reset, stimulus, idling and verdict.
`timescale 1ns / 1ps

module tb_top;
	import lpc_pkg::*;

	// Codes outside the package enums that the block must still handle.
	localparam logic [1:0] OP_UNUSED      = 2'd3;
	localparam logic [1:0] HEALTH_UNKNOWN = 2'd3;

	localparam int RANDOM_ITEMS   = 600;
	localparam int CALM_TAIL      = 60;
	localparam int HOLD_AT        = 80;
	localparam int LONG_HOLD      = 160;
	localparam int DRAIN_CYCLES   = 20;
	localparam int WATCHDOG_LIMIT = 3000;

	typedef struct {
		logic [1:0]  cmd;
		logic [15:0] tag;
		logic [7:0]  pulses;
		logic [15:0] period;
		logic [31:0] stamp;
		logic [1:0]  hl;
		logic [7:0]  red;
		logic [7:0]  green;
		logic [7:0]  blue;
		logic [7:0]  level;
		logic        lit;
	} cue_item_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;

	logic        in_valid;
	logic        in_stall;
	logic [1:0]  op;
	logic [15:0] cue_tag;
	logic [7:0]  pulse_count;
	logic [15:0] interval_ms;
	logic [31:0] now_ms;
	logic [1:0]  health;
	logic [7:0]  normal_red;
	logic [7:0]  normal_green;
	logic [7:0]  normal_blue;
	logic [7:0]  normal_brightness;
	logic        normal_on;

	logic        out_valid;
	logic        out_stall;
	logic [1:0]  command_result;
	logic [7:0]  out_red;
	logic [7:0]  out_green;
	logic [7:0]  out_blue;
	logic [7:0]  out_brightness;
	logic        out_on;
	logic [2:0]  cue_phase_state;
	logic [7:0]  pulses_done;

	int          fail_count;
	int          pending_results;

	// Shared control between the sender and the receiver processes.
	bit          random_phase = 1'b0;
	bit          calm = 1'b0;
	bit          hold_req = 1'b0;
	bit          send_gaps = 1'b1;
	int          random_sent = 0;
	int          quiet_cycles = 0;
	logic [31:0] clock_ms;
	logic [15:0] started [$];

	always #10 clk = ~clk;

	led_pulse_cue_controller_unit u_dut (.*);

	lpc_checker u_checker (.*);

	// A tick carries a random normal color; its command fields are noise the block ignores.
	function automatic cue_item_t tick_at(input logic [31:0] stamp, input logic [1:0] hl);
		cue_item_t it;
		it.cmd = OP_TICK;
		it.tag = 16'($urandom);
		it.pulses = 8'($urandom);
		it.period = 16'($urandom);
		it.stamp = stamp;
		it.hl = hl;
		it.red = 8'($urandom);
		it.green = 8'($urandom);
		it.blue = 8'($urandom);
		it.level = 8'($urandom);
		it.lit = 1'($urandom);
		return it;
	endfunction

	// A command with the one cue shape that the block accepts.
	function automatic cue_item_t command_at(input logic [1:0] cmd, input logic [15:0] tag,
		input logic [31:0] stamp, input logic [1:0] hl);
		cue_item_t it;
		it = tick_at(stamp, hl);
		it.cmd = cmd;
		it.tag = tag;
		it.pulses = CUE_PULSES;
		it.period = CUE_INTERVAL;
		return it;
	endfunction

	// Offers one transaction and holds it until the block takes it. Afterwards the
	// sender may go quiet for a random burst, except in the calm tail of the run.
	task automatic send_item(input cue_item_t it);
		op <= it.cmd;
		cue_tag <= it.tag;
		pulse_count <= it.pulses;
		interval_ms <= it.period;
		now_ms <= it.stamp;
		health <= it.hl;
		normal_red <= it.red;
		normal_green <= it.green;
		normal_blue <= it.blue;
		normal_brightness <= it.level;
		normal_on <= it.lit;
		in_valid <= 1'b1;
		do @(posedge clk); while (in_stall);
		if (random_phase && it.cmd != OP_UNUSED) begin
			random_sent++;
			if (random_sent % 37 == 0) begin
				send_gaps = ($urandom_range(0, 2) != 0);
			end
		end
		if (!calm && send_gaps && $urandom_range(0, 4) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 11)) @(posedge clk);
		end
	endtask

	// A well-formed cue: a start, then ticks walking forward in time with the odd
	// cancel, repeated start, malformed start or health drop mixed in.
	task automatic play_cue();
		cue_item_t it;
		logic [15:0] tag;
		logic [1:0] hl;
		int unsigned pick;
		// Small tags recur often, so repeats and ring eviction both come up.
		tag = ($urandom_range(0, 4) < 2) ? 16'($urandom_range(1, 12))
			: 16'($urandom_range(1, 65535));
		hl = ($urandom_range(0, 9) == 0) ? 2'($urandom_range(1, 3)) : 2'(HEALTH_OK);
		clock_ms += $urandom_range(0, 3000);
		send_item(command_at(OP_START, tag, clock_ms, hl));
		started.push_back(tag);
		if (started.size() > 16) begin
			void'(started.pop_front());
		end
		repeat ($urandom_range(4, 14)) begin
			clock_ms += ($urandom_range(0, 9) == 0) ? $urandom_range(0, 6000)
				: $urandom_range(0, 800);
			pick = $urandom_range(0, 99);
			if (pick < 6) begin
				it = command_at(OP_CANCEL, tag, clock_ms, HEALTH_OK);
			end else if (pick < 10) begin
				it = command_at(OP_START, started[$urandom_range(0, started.size() - 1)],
					clock_ms, HEALTH_OK);
			end else if (pick < 13) begin
				it = command_at(OP_START, 16'($urandom_range(1, 65535)), clock_ms, HEALTH_OK);
				it.pulses = 8'($urandom_range(0, 255));
				it.period = 16'($urandom_range(0, 65535));
			end else if (pick < 16) begin
				it = tick_at(clock_ms, HEALTH_DEGRADED);
			end else if (pick < 18) begin
				it = tick_at(clock_ms, ($urandom_range(0, 1) != 0) ? 2'(HEALTH_DOWN)
					: HEALTH_UNKNOWN);
			end else begin
				it = tick_at(clock_ms, HEALTH_OK);
			end
			send_item(it);
		end
	endtask

	// Anything the fields allow, with full-range time stamps and tags.
	function automatic cue_item_t noise_item();
		cue_item_t it;
		it = tick_at($urandom, 2'($urandom_range(0, 3)));
		it.cmd = 2'($urandom_range(0, 3));
		it.tag = ($urandom_range(0, 7) == 0) ? 16'd0 : 16'($urandom);
		it.pulses = ($urandom_range(0, 1) != 0) ? CUE_PULSES : 8'($urandom);
		it.period = ($urandom_range(0, 1) != 0) ? CUE_INTERVAL : 16'($urandom);
		return it;
	endfunction

	// Stimulus: reset, a directed walk through every case, then the random part.
	initial begin
		cue_item_t it;
		in_valid <= 1'b0;
		op <= OP_TICK;
		cue_tag <= 16'd0;
		pulse_count <= 8'd0;
		interval_ms <= 16'd0;
		now_ms <= 32'd0;
		health <= HEALTH_OK;
		normal_red <= 8'd0;
		normal_green <= 8'd0;
		normal_blue <= 8'd0;
		normal_brightness <= 8'd0;
		normal_on <= 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// Idle ticks with the normal color at both extremes.
		it = tick_at(32'd0, HEALTH_OK);
		{it.red, it.green, it.blue, it.level} = '1;
		it.lit = 1'b1;
		send_item(it);
		it = tick_at(32'd0, HEALTH_OK);
		{it.red, it.green, it.blue, it.level} = '0;
		it.lit = 1'b0;
		send_item(it);
		// Degraded blink: inside the first window, inside the second, and dark.
		send_item(tick_at(32'd100, HEALTH_DEGRADED));
		send_item(tick_at(32'd1300, HEALTH_DEGRADED));
		send_item(tick_at(32'd2500, HEALTH_DEGRADED));
		send_item(tick_at(32'd7, HEALTH_DOWN));
		send_item(tick_at(32'd8, HEALTH_UNKNOWN));
		// The unused operation changes nothing.
		it = tick_at($urandom, HEALTH_OK);
		it.cmd = OP_UNUSED;
		send_item(it);
		// Malformed starts and cancels.
		send_item(command_at(OP_START, 16'd0, 32'd0, HEALTH_OK));
		it = command_at(OP_START, 16'd5, 32'd0, HEALTH_OK);
		it.pulses = 8'd4;
		send_item(it);
		it.pulses = 8'hFF;
		send_item(it);
		it = command_at(OP_START, 16'd5, 32'd0, HEALTH_OK);
		it.period = 16'd999;
		send_item(it);
		it.period = 16'hFFFF;
		send_item(it);
		send_item(command_at(OP_CANCEL, 16'd0, 32'd0, HEALTH_OK));
		send_item(command_at(OP_CANCEL, 16'h1234, 32'd0, HEALTH_OK));
		// A full cue whose time base wraps through zero.
		clock_ms = 32'hFFFF_FE00;
		send_item(command_at(OP_START, 16'hFFFF, clock_ms, HEALTH_OK));
		send_item(tick_at(clock_ms, HEALTH_OK));
		send_item(tick_at(clock_ms + 32'd500, HEALTH_OK));
		send_item(tick_at(clock_ms + 32'd1999, HEALTH_OK));
		send_item(command_at(OP_START, 16'hFFFF, clock_ms, HEALTH_OK));
		send_item(tick_at(clock_ms + 32'd5000, HEALTH_OK));
		send_item(command_at(OP_CANCEL, 16'hFFFF, clock_ms, HEALTH_OK));
		// Start refused for health, a cancelled cue, and cues cut by health.
		send_item(command_at(OP_START, 16'd1, 32'd0, HEALTH_DEGRADED));
		send_item(command_at(OP_START, 16'd2, 32'd0, HEALTH_OK));
		send_item(tick_at(32'd250, HEALTH_OK));
		send_item(command_at(OP_CANCEL, 16'd2, 32'd300, HEALTH_OK));
		send_item(command_at(OP_CANCEL, 16'd2, 32'd400, HEALTH_OK));
		send_item(command_at(OP_START, 16'd3, 32'd1000, HEALTH_OK));
		send_item(tick_at(32'd1100, HEALTH_DOWN));
		send_item(command_at(OP_START, 16'd4, 32'd2000, HEALTH_OK));
		send_item(tick_at(32'd2100, HEALTH_DEGRADED));

		// Random part: mostly whole cues, some pure noise.
		clock_ms = 32'd3000;
		random_phase = 1'b1;
		while (random_sent < RANDOM_ITEMS) begin
			if (random_sent >= HOLD_AT) begin
				hold_req = 1'b1;
			end
			if (random_sent >= RANDOM_ITEMS - CALM_TAIL) begin
				calm = 1'b1;
			end
			if ($urandom_range(0, 9) < 7) begin
				play_cue();
			end else begin
				send_item(noise_item());
			end
		end
		in_valid <= 1'b0;

		// Wait for every outstanding result, then give the block time to show
		// anything unexpected before the verdict.
		while (pending_results != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

	// Receiver: random stall bursts in some windows, none in others, and one long
	// hold-off that lets the block fill up and push back on its input.
	initial begin
		int rx_cycles;
		bit stall_window;
		bit hold_done;
		rx_cycles = 0;
		stall_window = 1'b1;
		hold_done = 1'b0;
		out_stall <= 1'b0;
		wait (arst_n);
		forever begin
			@(posedge clk);
			rx_cycles++;
			if (rx_cycles % 97 == 0) begin
				stall_window = ($urandom_range(0, 1) != 0);
			end
			if (hold_req && !hold_done) begin
				hold_done = 1'b1;
				out_stall <= 1'b1;
				repeat (LONG_HOLD) @(posedge clk);
				out_stall <= 1'b0;
			end else if (!calm && stall_window && $urandom_range(0, 3) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 11)) @(posedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	// Watchdog: a run in which no transaction moves on either channel for too long has hung.
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("status: fail");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

endmodule
